// File: rtl/dbg_pkg.sv
// ----------------------------------------------------------------------------
// dbg_pkg
// Shared types and constants of the two-channel random gate router.
// ----------------------------------------------------------------------------
package dbg_pkg;

  // galois feedback taps and full-scale probability
  localparam logic [31:0] LfsrTaps  = 32'hD000_0001;
  localparam int unsigned HalfBits  = 16;
  localparam int unsigned ThrBits   = 17;

  // register indexes on the configuration port
  localparam logic [1:0] RegToggle = 2'd0;
  localparam logic [1:0] RegLatch  = 2'd1;
  localparam logic [1:0] RegSeed   = 2'd2;

  typedef struct packed {
    logic [1:0]  toggle;
    logic [1:0]  latch;
    logic        reload;
    logic [31:0] seed;
  } cfg_t;

  typedef struct packed {
    logic out_a;
    logic out_b;
    logic fresh;
  } res_t;

endpackage

// File: rtl/dbg_cfg.sv
// ----------------------------------------------------------------------------
// dbg_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module dbg_cfg import dbg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [1:0]  toggle_q, toggle_d;
  logic [1:0]  latch_q, latch_d;
  logic [31:0] seed_q, seed_d;
  logic        wr_en;
  logic        seed_wr;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign seed_wr = wr_en && (reg_idx == RegSeed);

  always_comb begin
    toggle_d = toggle_q;
    latch_d  = latch_q;
    seed_d   = seed_q;
    if (wr_en) begin
      case (reg_idx)
        RegToggle: toggle_d = pwdata[1:0];
        RegLatch:  latch_d  = pwdata[1:0];
        RegSeed:   seed_d   = pwdata;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      toggle_q <= 2'b00;
      latch_q  <= 2'b00;
      seed_q   <= 32'd1;
    end else begin
      toggle_q <= toggle_d;
      latch_q  <= latch_d;
      seed_q   <= seed_d;
    end
  end

  always_comb begin
    case (reg_idx)
      RegToggle: prdata = {30'd0, toggle_q};
      RegLatch:  prdata = {30'd0, latch_q};
      RegSeed:   prdata = seed_q;
      default:   prdata = 32'd0;
    endcase
  end

  // reload uses the written word directly so the generator matches the new seed
  assign cfg_o.toggle = toggle_q;
  assign cfg_o.latch  = latch_q;
  assign cfg_o.reload = seed_wr;
  assign cfg_o.seed   = pwdata;

endmodule

// File: rtl/dbg_core.sv
// ----------------------------------------------------------------------------
// dbg_core
// Generator, per-channel gate state and the decision logic for one word.
// ----------------------------------------------------------------------------
module dbg_core import dbg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               step_i,
  input  logic               channel_i,
  input  logic               gate_i,
  input  logic [ThrBits-1:0] threshold_i,
  output res_t               res_o
);

  logic [31:0] lfsr_q, lfsr_d;
  logic [1:0]  last_gate_q, last_gate_d;
  logic [1:0]  last_out_q, last_out_d;
  logic [1:0]  level_a_q, level_a_d;
  logic [1:0]  level_b_q, level_b_d;

  logic [HalfBits-1:0] slice;
  logic                hit;
  logic                outcome;
  logic                rise;
  logic                fall;

  assign slice   = channel_i ? lfsr_q[31:16] : lfsr_q[15:0];
  // a threshold of full scale or above always hits, which picks output a unless toggle inverts it
  assign hit     = threshold_i[ThrBits-1] || (slice < threshold_i[HalfBits-1:0]);
  assign outcome = hit ^ (cfg_i.toggle[channel_i] & last_out_q[channel_i]);
  assign rise    = gate_i && !last_gate_q[channel_i];
  assign fall    = !gate_i && last_gate_q[channel_i] && !cfg_i.latch[channel_i];

  always_comb begin
    lfsr_d      = lfsr_q;
    last_gate_d = last_gate_q;
    last_out_d  = last_out_q;
    level_a_d   = level_a_q;
    level_b_d   = level_b_q;
    if (cfg_i.reload) begin
      lfsr_d      = (cfg_i.seed == 32'd0) ? 32'd1 : cfg_i.seed;
      last_gate_d = 2'b00;
      last_out_d  = 2'b00;
      level_a_d   = 2'b00;
      level_b_d   = 2'b00;
    end else if (step_i) begin
      lfsr_d = (lfsr_q >> 1) ^ (lfsr_q[0] ? LfsrTaps : 32'd0);
      if (rise) begin
        last_out_d[channel_i] = outcome;
        level_a_d[channel_i]  = outcome;
        level_b_d[channel_i]  = ~outcome;
      end else if (fall) begin
        level_a_d[channel_i]  = 1'b0;
        level_b_d[channel_i]  = 1'b0;
      end
      last_gate_d[channel_i] = gate_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q      <= 32'd1;
      last_gate_q <= 2'b00;
      last_out_q  <= 2'b00;
      level_a_q   <= 2'b00;
      level_b_q   <= 2'b00;
    end else begin
      lfsr_q      <= lfsr_d;
      last_gate_q <= last_gate_d;
      last_out_q  <= last_out_d;
      level_a_q   <= level_a_d;
      level_b_q   <= level_b_d;
    end
  end

  assign res_o.out_a = level_a_d[channel_i];
  assign res_o.out_b = level_b_d[channel_i];
  assign res_o.fresh = rise;

endmodule

// File: rtl/dual_bernoulli_gate_top.sv
// ----------------------------------------------------------------------------
// dual_bernoulli_gate_top
// Two-channel random gate router with APB-style configuration.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while its input is not stalled and
// returns one result word for each, in order. A word is captured in an input
// register, decided against the shared generator and channel state as it
// moves on, and held in the result register until the output side takes it.
// The input register doubles as the skid stage: a new word is taken while a
// finished result still waits, and the input stalls only while both registers
// are full and the output side is stalled.
// Writing the seed register reloads the generator and clears both channels;
// configuration is expected only while no word is in flight.
module dual_bernoulli_gate_top import dbg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               channel_i,
  input  logic               gate_i,
  input  logic [ThrBits-1:0] threshold_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               out_a_o,
  output logic               out_b_o,
  output logic               fresh_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;
  res_t res;

  logic               s0_valid_q, s0_valid_d;
  logic               s0_chan_q;
  logic               s0_gate_q;
  logic [ThrBits-1:0] s0_thr_q;
  logic               out_valid_q, out_valid_d;
  res_t               out_q;
  logic               advance;
  logic               in_take;

  dbg_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dbg_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (advance),
    .channel_i   (s0_chan_q),
    .gate_i      (s0_gate_q),
    .threshold_i (s0_thr_q),
    .res_o       (res)
  );

  // word moves on when the result register is free or being emptied
  assign advance    = s0_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s0_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s0_valid_d  = in_take || (s0_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s0_valid_q  <= s0_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s0_chan_q <= channel_i;
      s0_gate_q <= gate_i;
      s0_thr_q  <= threshold_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_a_o     = out_q.out_a;
  assign out_b_o     = out_q.out_b;
  assign fresh_o     = out_q.fresh;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-channel random gate router. A table of
// gate words runs first: reset state, threshold extremes and saturation,
// held and falling gates. Random phases follow, each with its own toggle,
// latch and seed settings. Every accepted word is run through a local copy
// of the generator and channel state; each result word is checked in order
// against it or a typed row's value. Input idles, output stalls at random.
// ----------------------------------------------------------------------------
module tb import dbg_pkg::*; ();

  localparam logic [16:0] FullScale = 17'h10000;
  localparam logic [1:0]  RegUnused = 2'd3;
  localparam int          NumPhases = 6;
  localparam int          PhaseWords = 170;

  // expected levels {out_a, out_b, fresh}
  localparam res_t FreshA = 3'b101;
  localparam res_t FreshB = 3'b011;
  localparam res_t HeldB  = 3'b010;
  localparam res_t Clear  = 3'b000;
  localparam res_t Guess  = 3'b000;

  typedef struct packed {
    logic        ch;
    logic        gate;
    logic [16:0] thr;
    logic        typed;
    res_t        res;
  } row_t;

  row_t plan [16] = '{
    '{1'b0, 1'b1, 17'd0,      1'b1, FreshB},
    '{1'b0, 1'b1, 17'h10000,  1'b1, HeldB},
    '{1'b0, 1'b0, 17'd0,      1'b1, Clear},
    '{1'b0, 1'b1, 17'h10000,  1'b1, FreshA},
    '{1'b1, 1'b1, 17'h1ffff,  1'b1, FreshA},
    '{1'b1, 1'b0, 17'd0,      1'b1, Clear},
    '{1'b1, 1'b0, 17'h1ffff,  1'b1, Clear},
    '{1'b1, 1'b1, 17'd0,      1'b1, FreshB},
    '{1'b0, 1'b0, 17'd0,      1'b1, Clear},
    '{1'b0, 1'b1, 17'd32768,  1'b0, Guess},
    '{1'b1, 1'b0, 17'd1,      1'b1, Clear},
    '{1'b1, 1'b1, 17'd65535,  1'b0, Guess},
    '{1'b0, 1'b0, 17'h10001,  1'b1, Clear},
    '{1'b0, 1'b1, 17'h15555,  1'b1, FreshA},
    '{1'b0, 1'b0, 17'h0aaaa,  1'b1, Clear},
    '{1'b1, 1'b0, 17'h10000,  1'b1, Clear}
  };

  logic [1:0] tog_plan [NumPhases] = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0};
  logic [1:0] lat_plan [NumPhases] = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd3, 2'd0};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        channel_i;
  logic        gate_i;
  logic [16:0] threshold_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        out_a_o;
  logic        out_b_o;
  logic        fresh_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // typed expectation travelling with the current word
  logic        cur_typed;
  res_t        cur_res;

  // local copy of the block
  logic [31:0] gen;
  logic [1:0]  prev_gate;
  logic [1:0]  prev_outcome;
  logic [1:0]  lvl_a;
  logic [1:0]  lvl_b;
  logic [1:0]  tog_reg;
  logic [1:0]  latch_reg;
  logic [31:0] seed_reg;

  res_t pending_levels [$];
  int   faults = 0;

  dual_bernoulli_gate_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .channel_i   (channel_i),
    .gate_i      (gate_i),
    .threshold_i (threshold_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_a_o     (out_a_o),
    .out_b_o     (out_b_o),
    .fresh_o     (fresh_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    faults++;
    if (faults <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic reload_channels();
    gen          = (seed_reg != 32'd0) ? seed_reg : 32'd1;
    prev_gate    = 2'b00;
    prev_outcome = 2'b00;
    lvl_a        = 2'b00;
    lvl_b        = 2'b00;
  endtask

  task automatic cfg_write_model(input logic [1:0] idx, input logic [31:0] val);
    case (idx)
      RegToggle: tog_reg = val[1:0];
      RegLatch:  latch_reg = val[1:0];
      RegSeed: begin
        seed_reg = val;
        reload_channels();
      end
      default: ;
    endcase
  endtask

  task automatic gate_decide(input logic ch, input logic g, input logic [16:0] thr,
                             output res_t r);
    logic [16:0] lim;
    logic [15:0] slice;
    logic        outcome;
    logic        fresh;
    lim   = (thr > FullScale) ? FullScale : thr;
    fresh = 1'b0;
    if (g && !prev_gate[ch]) begin
      slice   = ch ? gen[31:16] : gen[15:0];
      outcome = ({1'b0, slice} < lim);
      if (tog_reg[ch]) begin
        outcome = outcome ^ prev_outcome[ch];
      end
      prev_outcome[ch] = outcome;
      lvl_a[ch]        = outcome;
      lvl_b[ch]        = ~outcome;
      fresh            = 1'b1;
    end else if (!g && prev_gate[ch] && !latch_reg[ch]) begin
      lvl_a[ch] = 1'b0;
      lvl_b[ch] = 1'b0;
    end
    prev_gate[ch] = g;
    gen = {1'b0, gen[31:1]} ^ (gen[0] ? LfsrTaps : 32'd0);
    r.out_a = lvl_a[ch];
    r.out_b = lvl_b[ch];
    r.fresh = fresh;
  endtask

  // words in on the input side, results checked on the output side, one edge
  always @(posedge clk_i) begin : scoreboard
    res_t want;
    res_t calc;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        gate_decide(channel_i, gate_i, threshold_i, calc);
        pending_levels.push_back(cur_typed ? cur_res : calc);
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_levels.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = pending_levels.pop_front();
          if (out_a_o !== want.out_a || out_b_o !== want.out_b ||
              fresh_o !== want.fresh) begin
            report($sformatf("mismatch: expected a=%0b b=%0b new=%0b, got a=%0b b=%0b new=%0b",
                             want.out_a, want.out_b, want.fresh,
                             out_a_o, out_b_o, fresh_o));
          end
        end
      end
    end
  end

  // mostly back to back or short, now and then a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [16:0] pick_thr();
    case ($urandom_range(0, 9))
      0:       return 17'd0;
      1:       return FullScale;
      2:       return 17'($urandom_range(65537, 131071));
      3, 4, 5: return {1'b0, 16'($urandom)};
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      int unsigned run;
      int unsigned hold;
      run  = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      hold = pick_gap();
      repeat (run) @(negedge clk_i) out_stall_i <= 1'b0;
      repeat (hold) @(negedge clk_i) out_stall_i <= 1'b1;
    end
  end

  task automatic send_word(input logic ch, input logic g, input logic [16:0] thr,
                           input logic typed, input res_t res);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    channel_i   <= ch;
    gate_i      <= g;
    threshold_i <= thr;
    cur_typed   <= typed;
    cur_res     <= res;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic go_quiet();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cfg_write_model(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_check(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i) penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    if (got !== want) begin
      report($sformatf("register %0d reads %h, expected %h", idx, got, want));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    apb_check(RegToggle, {30'd0, tog_reg});
    apb_check(RegLatch, {30'd0, latch_reg});
    apb_check(RegSeed, seed_reg);
  endtask

  initial begin
    logic        ch;
    logic        g;
    logic [31:0] sd;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    channel_i   = 1'b0;
    gate_i      = 1'b0;
    threshold_i = '0;
    cur_typed   = 1'b0;
    cur_res     = Clear;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    tog_reg     = 2'b00;
    latch_reg   = 2'b00;
    seed_reg    = 32'd1;
    reload_channels();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    check_regs();
    foreach (plan[i]) begin
      send_word(plan[i].ch, plan[i].gate, plan[i].thr, plan[i].typed, plan[i].res);
    end

    for (int p = 0; p < NumPhases; p++) begin
      go_quiet();
      case (p)
        0:       sd = 32'hffff_ffff;
        1:       sd = 32'd0;
        3:       sd = 32'h8000_0000;
        5:       sd = 32'd1;
        default: sd = $urandom;
      endcase
      // the spare address must leave everything as it was
      if (p == 4) begin
        apb_write(RegUnused, $urandom);
      end
      apb_write(RegToggle, {30'($urandom_range(0, 'h3fff_ffff)), tog_plan[p]});
      apb_write(RegLatch, {30'($urandom_range(0, 'h3fff_ffff)), lat_plan[p]});
      apb_write(RegSeed, sd);
      check_regs();
      for (int k = 0; k < PhaseWords; k++) begin
        if (p == 2 && k == PhaseWords / 2) begin
          go_quiet();
        end
        ch = 1'($urandom);
        // mostly real edges per channel, the rest a random level
        if ($urandom_range(0, 9) < 7) begin
          g = ~prev_gate[ch];
        end else begin
          g = 1'($urandom);
        end
        send_word(ch, g, pick_thr(), 1'b0, Guess);
      end
    end

    go_quiet();
    repeat (10) @(posedge clk_i);
    if (faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
